/* hw/rtl/ltds_pkg.sv */
`timescale 1ns / 1ps

package ltds_pkg;

   localparam int unsigned SampleWidth = 12;
   localparam int unsigned TimeWidth = 32;
   localparam int unsigned TimeoutWidth = 16;
   localparam int unsigned TacticWidth = 3;
   localparam int unsigned CsrDataWidth = 16;
   localparam int unsigned CsrIndexWidth = 2;

   typedef enum logic [2:0] {
      MOVE_STOP = 3'd0,
      MOVE_FWD = 3'd1,
      MOVE_BACK = 3'd2,
      MOVE_LEFT = 3'd3,
      MOVE_RIGHT = 3'd4,
      MOVE_SLIGHT_LEFT = 3'd5,
      MOVE_SLIGHT_RIGHT = 3'd6,
      MOVE_SLIGHT_BACK = 3'd7
   } move_type;

   typedef enum logic [1:0] {
      SEEN_NONE = 2'd0,
      SEEN_MID = 2'd1,
      SEEN_RIGHT = 2'd2,
      SEEN_LEFT = 2'd3
   } seen_type;

   localparam logic [TacticWidth-1:0] TACTIC_SPIN_LEFT = 3'd1;
   localparam logic [TacticWidth-1:0] TACTIC_SPIN_RIGHT = 3'd2;
   localparam logic [TacticWidth-1:0] TACTIC_ARC_LEFT = 3'd3;
   localparam logic [TacticWidth-1:0] TACTIC_ARC_RIGHT = 3'd4;
   localparam logic [TacticWidth-1:0] TACTIC_REVERSE = 3'd5;
   localparam logic [TacticWidth-1:0] TACTIC_FORWARD = 3'd7;

   localparam logic [CsrIndexWidth-1:0] CSR_FLOOR_THRESHOLD = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_OPENING_TACTIC = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_LONG_TIMEOUT = 2'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_SHORT_TIMEOUT = 2'd3;

   localparam logic [SampleWidth-1:0] FLOOR_THRESHOLD_RESET = 12'd2048;
   localparam logic [TacticWidth-1:0] OPENING_TACTIC_RESET = 3'd0;
   localparam logic [TimeoutWidth-1:0] LONG_TIMEOUT_RESET = 16'd500;
   localparam logic [TimeoutWidth-1:0] SHORT_TIMEOUT_RESET = 16'd350;

   typedef struct packed {
      logic [SampleWidth-1:0] floor_left_sample;
      logic [SampleWidth-1:0] floor_right_sample;
      logic enemy_mid;
      logic enemy_left;
      logic enemy_right;
      logic [TimeWidth-1:0] now_ms;
   } req_item_type;

   typedef struct packed {
      logic [SampleWidth-1:0] floor_threshold;
      logic [TacticWidth-1:0] opening_tactic;
      logic [TimeoutWidth-1:0] long_timeout_ms;
      logic [TimeoutWidth-1:0] short_timeout_ms;
   } cfg_type;

   typedef struct packed {
      move_type move;
      logic opening_active;
      logic line_left;
      logic line_right;
   } rsp_item_type;

endpackage

/* hw/rtl/ltds_decide.sv */
`timescale 1ns / 1ps

module ltds_decide (
   input  logic clock,
   input  logic reset,
   input  logic step,
   input  ltds_pkg::req_item_type item,
   input  ltds_pkg::cfg_type cfg,
   output ltds_pkg::rsp_item_type result
);

   logic in_opening_ff, in_opening_in;
   logic opening_started_ff, opening_started_in;
   logic [ltds_pkg::TimeWidth-1:0] opening_start_time_ff, opening_start_time_in;
   ltds_pkg::seen_type last_side_seen_ff, last_side_seen_in;
   ltds_pkg::move_type current_move_ff, current_move_in;

   logic line_left;
   logic line_right;
   logic [ltds_pkg::TimeWidth-1:0] start_base;
   logic [ltds_pkg::TimeWidth-1:0] elapsed;
   logic long_over;
   logic short_over;

   assign line_left = item.floor_left_sample <= cfg.floor_threshold;
   assign line_right = item.floor_right_sample <= cfg.floor_threshold;
   assign start_base = opening_started_ff ? opening_start_time_ff : item.now_ms;
   assign elapsed = item.now_ms - start_base;
   assign long_over = elapsed >
      {{(ltds_pkg::TimeWidth-ltds_pkg::TimeoutWidth){1'b0}}, cfg.long_timeout_ms};
   assign short_over = elapsed >
      {{(ltds_pkg::TimeWidth-ltds_pkg::TimeoutWidth){1'b0}}, cfg.short_timeout_ms};

   always_comb begin
      in_opening_in = in_opening_ff;
      opening_started_in = opening_started_ff;
      opening_start_time_in = opening_start_time_ff;
      last_side_seen_in = last_side_seen_ff;
      current_move_in = current_move_ff;
      priority if (line_left || line_right) begin
         in_opening_in = 1'b0;
         opening_started_in = 1'b0;
         opening_start_time_in = '0;
         priority if (line_left && line_right) begin
            current_move_in = ltds_pkg::MOVE_BACK;
         end else if (line_left) begin
            current_move_in = ltds_pkg::MOVE_RIGHT;
         end else begin
            current_move_in = ltds_pkg::MOVE_LEFT;
         end
      end else if (in_opening_ff) begin
         opening_started_in = 1'b1;
         opening_start_time_in = start_base;
         unique case (cfg.opening_tactic)
            ltds_pkg::TACTIC_SPIN_LEFT: begin
               current_move_in = ltds_pkg::MOVE_LEFT;
               if (item.enemy_mid || long_over) in_opening_in = 1'b0;
            end
            ltds_pkg::TACTIC_SPIN_RIGHT: begin
               current_move_in = ltds_pkg::MOVE_RIGHT;
               if (item.enemy_mid || long_over) in_opening_in = 1'b0;
            end
            ltds_pkg::TACTIC_ARC_LEFT: begin
               current_move_in = ltds_pkg::MOVE_SLIGHT_LEFT;
               if (short_over) in_opening_in = 1'b0;
            end
            ltds_pkg::TACTIC_ARC_RIGHT: begin
               current_move_in = ltds_pkg::MOVE_SLIGHT_RIGHT;
               if (short_over) in_opening_in = 1'b0;
            end
            ltds_pkg::TACTIC_REVERSE: begin
               current_move_in = ltds_pkg::MOVE_SLIGHT_BACK;
               if (short_over) in_opening_in = 1'b0;
            end
            ltds_pkg::TACTIC_FORWARD: begin
               current_move_in = ltds_pkg::MOVE_FWD;
               if (long_over) in_opening_in = 1'b0;
            end
            default: begin
               in_opening_in = 1'b0;
            end
         endcase
      end else begin
         priority if (item.enemy_mid) begin
            current_move_in = ltds_pkg::MOVE_FWD;
            last_side_seen_in = ltds_pkg::SEEN_MID;
         end else if (item.enemy_left) begin
            current_move_in = ltds_pkg::MOVE_LEFT;
            last_side_seen_in = ltds_pkg::SEEN_LEFT;
         end else if (item.enemy_right) begin
            current_move_in = ltds_pkg::MOVE_RIGHT;
            last_side_seen_in = ltds_pkg::SEEN_RIGHT;
         end else if (last_side_seen_ff == ltds_pkg::SEEN_LEFT) begin
            current_move_in = ltds_pkg::MOVE_LEFT;
         end else if (last_side_seen_ff == ltds_pkg::SEEN_RIGHT) begin
            current_move_in = ltds_pkg::MOVE_RIGHT;
         end else begin
            current_move_in = current_move_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_opening_ff <= 1'b1;
         opening_started_ff <= 1'b0;
         opening_start_time_ff <= '0;
         last_side_seen_ff <= ltds_pkg::SEEN_NONE;
         current_move_ff <= ltds_pkg::MOVE_STOP;
      end else if (step) begin
         in_opening_ff <= in_opening_in;
         opening_started_ff <= opening_started_in;
         opening_start_time_ff <= opening_start_time_in;
         last_side_seen_ff <= last_side_seen_in;
         current_move_ff <= current_move_in;
      end
   end

   assign result.move = current_move_in;
   assign result.opening_active = in_opening_in;
   assign result.line_left = line_left;
   assign result.line_right = line_right;

   a_line_ends_opening: assert property (@(posedge clock) disable iff (reset)
      step && (line_left || line_right) |=> !in_opening_ff && !opening_started_ff)
      else $error("line word left the opening phase active");

   a_opening_never_returns: assert property (@(posedge clock) disable iff (reset)
      !in_opening_ff |=> !in_opening_ff)
      else $error("opening phase came back without reset");

   a_idle_timer_zero: assert property (@(posedge clock) disable iff (reset)
      !opening_started_ff |-> opening_start_time_ff == '0)
      else $error("opening start time set while timer not started");

endmodule

/* hw/rtl/line_and_target_drive_selector.sv */
`timescale 1ns / 1ps

// line and target drive selector
// req channel: one control tick per word (floor samples, enemy bits, time in ms),
// valid/ready; rsp channel: one drive word per tick (move, opening flag, line
// flags), valid/ready, in tick order.
// csr port: write enable, index, 16-bit data; write only while no word is in flight.
// a word accepted into the input register is offered on rsp once it moves on to the output register.
// throughput: one word per cycle while rsp_ready is high; the decision is a single pass of compare and
// select logic between the input register and the output register.
// the input register takes a new word while a finished word waits in the
// output register; when rsp_ready stays low both registers fill and req_ready
// drops until the output word is taken.
// reset clears the pipeline, puts the block back in the opening phase with the
// timer not started, move stop, no side seen, and loads the register defaults
// (threshold 2048, tactic none, timeouts 500 and 350 ms).
module line_and_target_drive_selector (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [ltds_pkg::SampleWidth-1:0] req_floor_left_sample,
   input  logic [ltds_pkg::SampleWidth-1:0] req_floor_right_sample,
   input  logic req_enemy_mid,
   input  logic req_enemy_left,
   input  logic req_enemy_right,
   input  logic [ltds_pkg::TimeWidth-1:0] req_now_ms,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [2:0] rsp_move,
   output logic rsp_opening_active,
   output logic rsp_line_left,
   output logic rsp_line_right,
   input  logic csr_write_enable,
   input  logic [ltds_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [ltds_pkg::CsrDataWidth-1:0] csr_write_data
);

   ltds_pkg::cfg_type cfg_ff;
   logic s1_valid_ff;
   ltds_pkg::req_item_type s1_item_ff;
   logic rsp_valid_ff;
   ltds_pkg::rsp_item_type rsp_item_ff;
   ltds_pkg::rsp_item_type result;
   logic out_free;
   logic advance;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign advance = s1_valid_ff && out_free;
   assign req_ready = !s1_valid_ff || out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.floor_threshold <= ltds_pkg::FLOOR_THRESHOLD_RESET;
         cfg_ff.opening_tactic <= ltds_pkg::OPENING_TACTIC_RESET;
         cfg_ff.long_timeout_ms <= ltds_pkg::LONG_TIMEOUT_RESET;
         cfg_ff.short_timeout_ms <= ltds_pkg::SHORT_TIMEOUT_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            ltds_pkg::CSR_FLOOR_THRESHOLD:
               cfg_ff.floor_threshold <= csr_write_data[ltds_pkg::SampleWidth-1:0];
            ltds_pkg::CSR_OPENING_TACTIC:
               cfg_ff.opening_tactic <= csr_write_data[ltds_pkg::TacticWidth-1:0];
            ltds_pkg::CSR_LONG_TIMEOUT:
               cfg_ff.long_timeout_ms <= csr_write_data[ltds_pkg::TimeoutWidth-1:0];
            ltds_pkg::CSR_SHORT_TIMEOUT:
               cfg_ff.short_timeout_ms <= csr_write_data[ltds_pkg::TimeoutWidth-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_ready) s1_valid_ff <= req_valid;
         if (out_free) rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_item_ff.floor_left_sample <= req_floor_left_sample;
         s1_item_ff.floor_right_sample <= req_floor_right_sample;
         s1_item_ff.enemy_mid <= req_enemy_mid;
         s1_item_ff.enemy_left <= req_enemy_left;
         s1_item_ff.enemy_right <= req_enemy_right;
         s1_item_ff.now_ms <= req_now_ms;
      end
      if (advance) rsp_item_ff <= result;
   end

   ltds_decide u_decide (
      .clock(clock),
      .reset(reset),
      .step(advance),
      .item(s1_item_ff),
      .cfg(cfg_ff),
      .result(result)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_move = rsp_item_ff.move;
   assign rsp_opening_active = rsp_item_ff.opening_active;
   assign rsp_line_left = rsp_item_ff.line_left;
   assign rsp_line_right = rsp_item_ff.line_right;

   a_full_blocks_input: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && rsp_valid_ff && !rsp_ready |-> !req_ready)
      else $error("input taken while both stages are full and stalled");

   a_word_reaches_output: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("decided word did not reach the output register");

   a_output_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> rsp_valid_ff && $stable(rsp_item_ff))
      else $error("stalled output word changed before it was taken");

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps

module testbench;

   localparam logic [ltds_pkg::TacticWidth-1:0] TACTIC_NONE = 3'd0;
   localparam logic [ltds_pkg::TacticWidth-1:0] TACTIC_UNUSED = 3'd6;

   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_COIN,
      READY_SPARSE,
      READY_STALLS
   } ready_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [ltds_pkg::SampleWidth-1:0] req_floor_left_sample = '0;
   logic [ltds_pkg::SampleWidth-1:0] req_floor_right_sample = '0;
   logic req_enemy_mid = 1'b0;
   logic req_enemy_left = 1'b0;
   logic req_enemy_right = 1'b0;
   logic [ltds_pkg::TimeWidth-1:0] req_now_ms = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [2:0] rsp_move;
   logic rsp_opening_active;
   logic rsp_line_left;
   logic rsp_line_right;
   logic csr_write_enable = 1'b0;
   logic [ltds_pkg::CsrIndexWidth-1:0] csr_index = '0;
   logic [ltds_pkg::CsrDataWidth-1:0] csr_write_data = '0;

   line_and_target_drive_selector dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_floor_left_sample(req_floor_left_sample),
      .req_floor_right_sample(req_floor_right_sample),
      .req_enemy_mid(req_enemy_mid),
      .req_enemy_left(req_enemy_left),
      .req_enemy_right(req_enemy_right),
      .req_now_ms(req_now_ms),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_move(rsp_move),
      .rsp_opening_active(rsp_opening_active),
      .rsp_line_left(rsp_line_left),
      .rsp_line_right(rsp_line_right),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always #5 clock = ~clock;

   // register copy
   logic [ltds_pkg::SampleWidth-1:0] floor_level = ltds_pkg::FLOOR_THRESHOLD_RESET;
   logic [ltds_pkg::TacticWidth-1:0] tactic_sel = ltds_pkg::OPENING_TACTIC_RESET;
   logic [ltds_pkg::TimeoutWidth-1:0] long_limit = ltds_pkg::LONG_TIMEOUT_RESET;
   logic [ltds_pkg::TimeoutWidth-1:0] short_limit = ltds_pkg::SHORT_TIMEOUT_RESET;

   // decision state copy
   logic opening_on = 1'b1;
   logic opening_timer_on = 1'b0;
   logic [ltds_pkg::TimeWidth-1:0] opening_t0 = '0;
   ltds_pkg::seen_type side_memory = ltds_pkg::SEEN_NONE;
   ltds_pkg::move_type move_now = ltds_pkg::MOVE_STOP;

   ltds_pkg::req_item_type pending_ticks[$];
   ltds_pkg::rsp_item_type expected_drive[$];
   ltds_pkg::req_item_type held_word;
   ltds_pkg::rsp_item_type wanted_drive;
   int unsigned queued_words = 0;
   int unsigned accepted_words = 0;
   int unsigned failures = 0;
   int unsigned burst_left = 8;
   int unsigned gap_left = 0;
   ready_mode_type ready_mode = READY_ALWAYS;
   int unsigned mode_left = 0;
   int unsigned stall_left = 0;

   task automatic predict_drive(input ltds_pkg::req_item_type w);
      ltds_pkg::rsp_item_type r;
      logic line_l;
      logic line_r;
      logic [ltds_pkg::TimeWidth-1:0] elapsed;
      line_l = w.floor_left_sample <= floor_level;
      line_r = w.floor_right_sample <= floor_level;
      if (line_l || line_r) begin
         opening_on = 1'b0;
         opening_timer_on = 1'b0;
         opening_t0 = '0;
         if (line_l && line_r) begin
            move_now = ltds_pkg::MOVE_BACK;
         end else if (line_l) begin
            move_now = ltds_pkg::MOVE_RIGHT;
         end else begin
            move_now = ltds_pkg::MOVE_LEFT;
         end
      end else if (opening_on) begin
         if (!opening_timer_on) begin
            opening_t0 = w.now_ms;
            opening_timer_on = 1'b1;
         end
         elapsed = w.now_ms - opening_t0;
         case (tactic_sel)
            ltds_pkg::TACTIC_SPIN_LEFT: begin
               move_now = ltds_pkg::MOVE_LEFT;
               if (w.enemy_mid || elapsed > long_limit) opening_on = 1'b0;
            end
            ltds_pkg::TACTIC_SPIN_RIGHT: begin
               move_now = ltds_pkg::MOVE_RIGHT;
               if (w.enemy_mid || elapsed > long_limit) opening_on = 1'b0;
            end
            ltds_pkg::TACTIC_ARC_LEFT: begin
               move_now = ltds_pkg::MOVE_SLIGHT_LEFT;
               if (elapsed > short_limit) opening_on = 1'b0;
            end
            ltds_pkg::TACTIC_ARC_RIGHT: begin
               move_now = ltds_pkg::MOVE_SLIGHT_RIGHT;
               if (elapsed > short_limit) opening_on = 1'b0;
            end
            ltds_pkg::TACTIC_REVERSE: begin
               move_now = ltds_pkg::MOVE_SLIGHT_BACK;
               if (elapsed > short_limit) opening_on = 1'b0;
            end
            ltds_pkg::TACTIC_FORWARD: begin
               move_now = ltds_pkg::MOVE_FWD;
               if (elapsed > long_limit) opening_on = 1'b0;
            end
            default: opening_on = 1'b0;
         endcase
      end else if (w.enemy_mid) begin
         move_now = ltds_pkg::MOVE_FWD;
         side_memory = ltds_pkg::SEEN_MID;
      end else if (w.enemy_left) begin
         move_now = ltds_pkg::MOVE_LEFT;
         side_memory = ltds_pkg::SEEN_LEFT;
      end else if (w.enemy_right) begin
         move_now = ltds_pkg::MOVE_RIGHT;
         side_memory = ltds_pkg::SEEN_RIGHT;
      end else if (side_memory == ltds_pkg::SEEN_LEFT) begin
         move_now = ltds_pkg::MOVE_LEFT;
      end else if (side_memory == ltds_pkg::SEEN_RIGHT) begin
         move_now = ltds_pkg::MOVE_RIGHT;
      end
      r.move = move_now;
      r.opening_active = opening_on;
      r.line_left = line_l;
      r.line_right = line_r;
      expected_drive.push_back(r);
   endtask

   function automatic logic receiver_ready();
      if (mode_left == 0) begin
         ready_mode = ready_mode_type'($urandom_range(0, 3));
         mode_left = $urandom_range(20, 120);
      end
      mode_left--;
      case (ready_mode)
         READY_ALWAYS: return 1'b1;
         READY_COIN: return 1'($urandom_range(0, 1));
         READY_SPARSE: return $urandom_range(0, 3) == 0;
         default: begin
            if (stall_left > 0) begin
               stall_left--;
               return 1'b0;
            end
            stall_left = $urandom_range(1, 20);
            return 1'b1;
         end
      endcase
   endfunction

   // sender: bursts of words with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predict_drive(held_word);
            accepted_words++;
         end
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_ticks.size() > 0) begin
               held_word = pending_ticks.pop_front();
               req_floor_left_sample <= held_word.floor_left_sample;
               req_floor_right_sample <= held_word.floor_right_sample;
               req_enemy_mid <= held_word.enemy_mid;
               req_enemy_left <= held_word.enemy_left;
               req_enemy_right <= held_word.enemy_right;
               req_now_ms <= held_word.now_ms;
               req_valid <= 1'b1;
               burst_left--;
               if (burst_left == 0) begin
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                  burst_left = $urandom_range(1, 30);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver: checks each drive word against the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_drive.size() == 0) begin
               $error("unexpected drive word: move %0d", rsp_move);
               failures++;
            end else begin
               wanted_drive = expected_drive.pop_front();
               if (rsp_move !== wanted_drive.move) begin
                  $error("move: expected %0d, got %0d", wanted_drive.move, rsp_move);
                  failures++;
               end
               if (rsp_opening_active !== wanted_drive.opening_active) begin
                  $error("opening_active: expected %0d, got %0d",
                     wanted_drive.opening_active, rsp_opening_active);
                  failures++;
               end
               if (rsp_line_left !== wanted_drive.line_left) begin
                  $error("line_left: expected %0d, got %0d",
                     wanted_drive.line_left, rsp_line_left);
                  failures++;
               end
               if (rsp_line_right !== wanted_drive.line_right) begin
                  $error("line_right: expected %0d, got %0d",
                     wanted_drive.line_right, rsp_line_right);
                  failures++;
               end
            end
         end
         rsp_ready <= receiver_ready();
      end
   end

   task automatic settle();
      while (accepted_words != queued_words || expected_drive.size() != 0) begin
         @(posedge clock);
      end
      repeat (3) @(posedge clock);
   endtask

   task automatic write_reg(input logic [ltds_pkg::CsrIndexWidth-1:0] idx,
                            input logic [ltds_pkg::CsrDataWidth-1:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      case (idx)
         ltds_pkg::CSR_FLOOR_THRESHOLD: floor_level = data[ltds_pkg::SampleWidth-1:0];
         ltds_pkg::CSR_OPENING_TACTIC: tactic_sel = data[ltds_pkg::TacticWidth-1:0];
         ltds_pkg::CSR_LONG_TIMEOUT: long_limit = data;
         ltds_pkg::CSR_SHORT_TIMEOUT: short_limit = data;
         default: ;
      endcase
   endtask

   task automatic apply_settings(input logic [ltds_pkg::SampleWidth-1:0] thr,
                                 input logic [ltds_pkg::TacticWidth-1:0] tac,
                                 input logic [ltds_pkg::TimeoutWidth-1:0] lto,
                                 input logic [ltds_pkg::TimeoutWidth-1:0] sto);
      settle();
      write_reg(ltds_pkg::CSR_FLOOR_THRESHOLD, 16'(thr));
      write_reg(ltds_pkg::CSR_OPENING_TACTIC, 16'(tac));
      write_reg(ltds_pkg::CSR_LONG_TIMEOUT, lto);
      write_reg(ltds_pkg::CSR_SHORT_TIMEOUT, sto);
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic send_tick(input logic [ltds_pkg::SampleWidth-1:0] fl,
                            input logic [ltds_pkg::SampleWidth-1:0] fr,
                            input logic m, input logic l, input logic r,
                            input logic [ltds_pkg::TimeWidth-1:0] now);
      ltds_pkg::req_item_type w;
      w.floor_left_sample = fl;
      w.floor_right_sample = fr;
      w.enemy_mid = m;
      w.enemy_left = l;
      w.enemy_right = r;
      w.now_ms = now;
      pending_ticks.push_back(w);
      queued_words++;
   endtask

   // a sample on the line or on dark floor for the current threshold
   function automatic logic [ltds_pkg::SampleWidth-1:0] floor_value(input bit on_line);
      if (on_line || floor_level == 12'hFFF) begin
         case ($urandom_range(0, 3))
            0: return floor_level;
            1: return '0;
            default: return 12'($urandom_range(0, 32'(floor_level)));
         endcase
      end
      case ($urandom_range(0, 3))
         0: return floor_level + 12'd1;
         1: return 12'hFFF;
         default: return 12'($urandom_range(32'(floor_level) + 1, 4095));
      endcase
   endfunction

   function automatic logic [ltds_pkg::TimeoutWidth-1:0] pick_limit();
      case ($urandom_range(0, 2))
         0: return '0;
         1: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      logic [ltds_pkg::TacticWidth-1:0] tour [0:5];
      logic [ltds_pkg::TacticWidth-1:0] tac;
      logic [ltds_pkg::TimeWidth-1:0] open_ms;
      logic [ltds_pkg::TimeWidth-1:0] origin_ms;
      logic [ltds_pkg::TimeWidth-1:0] el;
      logic [ltds_pkg::SampleWidth-1:0] thr;
      bit spin;
      int unsigned ending;
      int unsigned pick;
      tour = '{ltds_pkg::TACTIC_SPIN_LEFT, ltds_pkg::TACTIC_SPIN_RIGHT,
               ltds_pkg::TACTIC_ARC_LEFT, ltds_pkg::TACTIC_ARC_RIGHT,
               ltds_pkg::TACTIC_REVERSE, ltds_pkg::TACTIC_FORWARD};
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // opening: walk through every tactic without letting the run end
      open_ms = $urandom_range(0, 1) ? 32'hFFFF_FFFC : $urandom;
      origin_ms = open_ms;
      for (int i = 0; i < 6; i++) begin
         apply_settings(12'd100, tour[i], 16'hFFFF, 16'hFFFF);
         spin = tour[i] == ltds_pkg::TACTIC_SPIN_LEFT ||
            tour[i] == ltds_pkg::TACTIC_SPIN_RIGHT;
         repeat (2) begin
            send_tick(floor_value(0), floor_value(0), spin ? 1'b0 : 1'($urandom_range(0, 1)),
               1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), open_ms);
            open_ms += $urandom_range(0, 3);
         end
      end

      // one way out of the opening, chosen at random
      el = open_ms - origin_ms;
      ending = $urandom_range(0, 4);
      case (ending)
         0, 1: begin
            if (ending == 0) begin
               apply_settings(12'd100, ltds_pkg::TACTIC_FORWARD, el[15:0], 16'hFFFF);
            end else begin
               tac = ($urandom_range(0, 2) == 0) ? ltds_pkg::TACTIC_ARC_LEFT :
                  ($urandom_range(0, 1) ? ltds_pkg::TACTIC_ARC_RIGHT :
                   ltds_pkg::TACTIC_REVERSE);
               apply_settings(12'd100, tac, 16'hFFFF, el[15:0]);
            end
            send_tick(floor_value(0), floor_value(0), 1'b0, 1'b1, 1'b0, open_ms);
            send_tick(floor_value(0), floor_value(0), 1'b0, 1'b0, 1'b1, open_ms + 1);
         end
         2: begin
            apply_settings(12'd100, $urandom_range(0, 1) ? ltds_pkg::TACTIC_SPIN_LEFT :
               ltds_pkg::TACTIC_SPIN_RIGHT, 16'hFFFF, 16'hFFFF);
            send_tick(floor_value(0), floor_value(0), 1'b1, 1'b0, 1'b0, open_ms);
         end
         3: begin
            send_tick(floor_value(1), floor_value($urandom_range(0, 1)), 1'b1, 1'b1, 1'b1,
               open_ms);
         end
         default: begin
            apply_settings(12'd100, $urandom_range(0, 1) ? TACTIC_NONE : TACTIC_UNUSED,
               16'hFFFF, 16'hFFFF);
            send_tick(floor_value(0), floor_value(0), 1'b0, 1'b0, 1'b0, open_ms);
         end
      endcase

      // normal phase: chase order, side memory and line reactions
      send_tick(12'd2000, 12'd3000, 1'b0, 1'b0, 1'b0, 32'd0);
      send_tick(12'hFFF, 12'hFFF, 1'b1, 1'b0, 1'b0, 32'd5);
      send_tick(12'd101, 12'd101, 1'b0, 1'b0, 1'b0, 32'd9);
      send_tick(12'd500, 12'd600, 1'b0, 1'b1, 1'b0, 32'd10);
      send_tick(12'd700, 12'd800, 1'b0, 1'b0, 1'b0, 32'd11);
      send_tick(12'd900, 12'd1000, 1'b0, 1'b0, 1'b1, 32'd12);
      send_tick(12'd1100, 12'd1200, 1'b0, 1'b0, 1'b0, 32'd13);
      send_tick(12'd1300, 12'd1400, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF);
      send_tick(12'd1500, 12'd1600, 1'b0, 1'b1, 1'b1, 32'h8000_0000);
      send_tick(12'd0, 12'd0, 1'b1, 1'b0, 1'b1, 32'h5555_5555);
      send_tick(12'd100, 12'd101, 1'b0, 1'b1, 1'b0, 32'hAAAA_AAAA);
      send_tick(12'd101, 12'd100, 1'b1, 1'b1, 1'b1, 32'd77);

      // random phases, each under its own register settings
      for (int p = 0; p < 8; p++) begin
         case (p)
            0: thr = 12'd0;
            1: thr = 12'hFFF;
            2: thr = ltds_pkg::FLOOR_THRESHOLD_RESET;
            default: thr = 12'($urandom_range(0, 4095));
         endcase
         apply_settings(thr, 3'($urandom_range(0, 7)), pick_limit(), pick_limit());
         repeat (144) begin
            pick = $urandom_range(0, 9);
            send_tick(floor_value(pick == 0 || pick == 2), floor_value(pick == 1 || pick == 2),
               $urandom_range(0, 3) == 0, $urandom_range(0, 2) == 0,
               $urandom_range(0, 2) == 0, $urandom);
         end
      end

      settle();
      repeat (10) @(posedge clock);
      if (failures == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
